/* design/lcpd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lcpd_pkg;

  localparam int unsigned PWM_PERIOD_DEF = 20;
  localparam int unsigned PATTERN_STEPS  = 25;

  localparam int unsigned IVL_W    = 11;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned LED_W    = 8;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned LEVEL_W  = 3;
  localparam int unsigned POT_W    = 8;
  localparam int unsigned IN_DW    = 8;
  localparam int unsigned OUT_DW   = 16;

  localparam logic [IVL_W-1:0] INTERVAL_RST = 11'd400;
  localparam logic [LED_W-1:0] LED_ALL_OFF  = 8'hff;

  localparam logic [POT_W-1:0] POT_TH_HI  = 8'd192;
  localparam logic [POT_W-1:0] POT_TH_MID = 8'd128;
  localparam logic [POT_W-1:0] POT_TH_LO  = 8'd64;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_TOGGLE = 1'b1;

  typedef struct packed {
    logic               paused;
    logic [LEVEL_W-1:0] brightness;
    logic [MODE_W-1:0]  run_mode;
    logic [LED_W-1:0]   led_drive;
  } lcpd_result_t;

  function automatic logic [LED_W-1:0] pattern_for(input logic [STEP_W-1:0] s);
    logic [LED_W-1:0]  lit;
    logic [STEP_W-1:0] d;
    begin
      lit = '0;
      d   = '0;
      if (s >= 5'd1 && s <= 5'd8) begin
        d   = s - 5'd1;
        lit = 8'h01 << d[2:0];
      end else if (s >= 5'd9 && s <= 5'd16) begin
        d   = s - 5'd9;
        lit = 8'h80 >> d[2:0];
      end else if (s >= 5'd17 && s <= 5'd24) begin
        d   = s - 5'd17;
        lit = (8'h80 >> d[2:0]) | (8'h01 << d[2:0]);
      end
      return ~lit;
    end
  endfunction

  function automatic logic [MODE_W-1:0] mode_for(input logic [STEP_W-1:0] s);
    if (s >= 5'd21) return 3'd4;
    if (s >= 5'd17) return 3'd3;
    if (s >= 5'd9)  return 3'd2;
    return 3'd1;
  endfunction

  function automatic logic [LEVEL_W-1:0] level_for(input logic [POT_W-1:0] p);
    if (p >= POT_TH_HI)  return 3'd4;
    if (p >= POT_TH_MID) return 3'd3;
    if (p >= POT_TH_LO)  return 3'd2;
    return 3'd1;
  endfunction

endpackage
`default_nettype wire

/* design/lcpd_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module lcpd_core #(
  parameter int unsigned PWM_PERIOD = lcpd_pkg::PWM_PERIOD_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        step_en,
  input  wire logic                        cmd,
  input  wire logic [lcpd_pkg::POT_W-1:0]  pot,
  input  wire logic [lcpd_pkg::IVL_W-1:0]  interval,
  output lcpd_pkg::lcpd_result_t           res_nxt
);
  import lcpd_pkg::*;

  localparam int unsigned PW = $clog2(PWM_PERIOD + 1);
  localparam int unsigned SW = PW + 5;
  localparam logic [PW-1:0] PERIOD_PW = PW'(PWM_PERIOD);
  localparam logic [SW-1:0] PERIOD_SW = SW'(PWM_PERIOD);
  localparam logic [STEP_W-1:0] STEPS = STEP_W'(PATTERN_STEPS);

  logic [IVL_W-1:0]   step_ticks_r, step_ticks_nxt;
  logic [STEP_W-1:0]  pattern_step_r, pattern_step_nxt;
  logic [PW-1:0]      pwm_ticks_r, pwm_ticks_nxt;
  logic [LED_W-1:0]   latch_r, latch_nxt;
  logic [LED_W-1:0]   port_r, port_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               frozen_r, frozen_nxt;

  logic [IVL_W:0]     st_sum;
  logic [STEP_W-1:0]  ps_inc;
  logic [PW-1:0]      pw_inc;
  logic [SW-1:0]      pw_cmp;
  logic               run_tick;

  always_comb begin
    step_ticks_nxt   = step_ticks_r;
    pattern_step_nxt = pattern_step_r;
    pwm_ticks_nxt    = pwm_ticks_r;
    latch_nxt        = latch_r;
    port_nxt         = port_r;
    mode_nxt         = mode_r;
    level_nxt        = level_r;
    frozen_nxt       = frozen_r;
    run_tick         = (cmd == CMD_TICK) && !frozen_r;
    st_sum           = {1'b0, step_ticks_r} + {{IVL_W{1'b0}}, 1'b1};
    ps_inc           = pattern_step_r;
    pw_inc           = pwm_ticks_r + {{(PW-1){1'b0}}, 1'b1};
    pw_cmp           = '0;

    if (cmd == CMD_TOGGLE) begin
      frozen_nxt = ~frozen_r;
    end else begin
      level_nxt = level_for(pot);
    end

    if (run_tick) begin
      if (st_sum >= {1'b0, interval}) begin
        step_ticks_nxt = '0;
        ps_inc         = pattern_step_r + 5'd1;
      end else begin
        step_ticks_nxt = st_sum[IVL_W-1:0];
      end
      pattern_step_nxt = (ps_inc >= STEPS) ? '0 : ps_inc;

      // drive pattern once count + 1 + 5*level reaches the period; blank at wrap
      pw_cmp = SW'(pw_inc) + SW'({level_nxt, 2'b00}) + SW'(level_nxt);
      pwm_ticks_nxt = pw_inc;
      if (pw_cmp >= PERIOD_SW) begin
        port_nxt = latch_r;
        if (pw_inc >= PERIOD_PW) begin
          pwm_ticks_nxt = '0;
          port_nxt      = LED_ALL_OFF;
          latch_nxt     = pattern_for(pattern_step_nxt);
          mode_nxt      = mode_for(pattern_step_nxt);
        end
      end
    end

    res_nxt.led_drive  = port_nxt;
    res_nxt.run_mode   = mode_nxt;
    res_nxt.brightness = level_nxt;
    res_nxt.paused     = frozen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_ticks_r   <= '0;
      pattern_step_r <= '0;
      pwm_ticks_r    <= '0;
      latch_r        <= LED_ALL_OFF;
      port_r         <= LED_ALL_OFF;
      mode_r         <= 3'd1;
      level_r        <= 3'd1;
      frozen_r       <= 1'b0;
    end else if (step_en) begin
      step_ticks_r   <= step_ticks_nxt;
      pattern_step_r <= pattern_step_nxt;
      pwm_ticks_r    <= pwm_ticks_nxt;
      latch_r        <= latch_nxt;
      port_r         <= port_nxt;
      mode_r         <= mode_nxt;
      level_r        <= level_nxt;
      frozen_r       <= frozen_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/led_chaser_pwm_dimmer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Eight-LED chaser with four-level PWM dimming. Each input word is either a
// 1 ms tick carrying a pot sample (tuser = 0) or a run/pause toggle
// (tuser = 1); every word produces exactly one result word with the
// active-low LED port value, mode, brightness and paused flag. The whole
// update is combinational logic between the state registers and the output
// register, so a word is accepted every cycle while the output register is
// empty or being drained. The user must write the step interval via the cfg
// port (always ready) only while no word is in flight; nothing enforces it.
module led_chaser_pwm_dimmer #(
  parameter int unsigned PWM_PERIOD = lcpd_pkg::PWM_PERIOD_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output      logic                         in_tready,
  input  wire logic [lcpd_pkg::IN_DW-1:0]   in_tdata,  // [7:0] pot_sample
  input  wire logic                         in_tuser,  // [0] cmd
  output      logic                         out_tvalid,
  input  wire logic                         out_tready,
  // [7:0] led_drive, [10:8] run_mode, [13:11] brightness, [14] paused
  output      logic [lcpd_pkg::OUT_DW-1:0]  out_tdata,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [lcpd_pkg::IVL_W-1:0]   cfg_data
);
  import lcpd_pkg::*;

  logic [IVL_W-1:0] interval_r;
  logic             out_valid_r;
  lcpd_result_t     res_r;
  lcpd_result_t     res_nxt;
  logic             in_acc;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DW - $bits(lcpd_result_t)){1'b0}}, res_r};

  lcpd_core #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_acc),
    .cmd      (in_tuser),
    .pot      (in_tdata[POT_W-1:0]),
    .interval (interval_r),
    .res_nxt  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      interval_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire
